// File: rtl/drc_pkg.sv
// Shared types, widths and constants for the depth region-of-interest centroid block.
package drc_pkg;

   localparam int COORD_W    = 14;
   localparam int INV_W      = 24;
   localparam int DEPTH_W    = 16;
   localparam int COUNT_W    = 19;
   localparam int SUM_XY_W   = 56;
   localparam int SUM_Z_W    = 32;
   localparam int MUL_A_W    = 30;
   localparam int PROD_W     = MUL_A_W + INV_W;
   localparam int FRAC_SHIFT = 20;
   localparam int TERM_W     = PROD_W - FRAC_SHIFT;
   localparam int DIV_W      = 46;
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int OUT_W      = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_PRINCIPAL_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRINCIPAL_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_LIMIT = 3'd4;

   localparam logic [COORD_W-1:0] PRINCIPAL_X_RESET = 14'd5120;
   localparam logic [COORD_W-1:0] PRINCIPAL_Y_RESET = 14'd3840;
   localparam logic [INV_W-1:0]   INV_FOCAL_RESET   = 24'd33554;
   localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RESET = 16'd3600;

   localparam logic [OUT_W-1:0] OUT_POS_MAX = 16'h7FFF;
   localparam logic [OUT_W-1:0] OUT_NEG_MIN = 16'h8000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_XA,
      S_XB,
      S_YA,
      S_YB,
      S_ACC,
      S_FIN,
      S_DIV_X,
      S_DIV_Y,
      S_DIV_Z,
      S_OUT
   } state_type;

endpackage

// File: rtl/drc_divider.sv
// Iterative restoring divider that produces one quotient bit per cycle.
module drc_divider
   import drc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_W-1:0]   dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               done,
   output logic [DIV_W-1:0]   quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [COUNT_W-1:0]   rem_ff;
   logic [DIV_W-1:0]     quo_ff;

   logic [COUNT_W:0]   trial;
   logic               ge;
   logic [COUNT_W-1:0] rem_in;
   logic [DIV_W-1:0]   quo_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      ge     = trial >= {1'b0, divisor};
      rem_in = ge ? COUNT_W'(trial - {1'b0, divisor}) : trial[COUNT_W-1:0];
      quo_in = {quo_ff[DIV_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/depth_roi_centroid.sv
// Top level: pinhole back-projection and centroid of the valid depth pixels of a box.
// A valid pixel holds the block through S_XA, S_XB, S_YA, S_YB and S_ACC; a skipped pixel
// is dropped in S_IDLE. The last pixel of a box adds three divisions on the shared divider
// (none for an empty box) before the result is presented.
// One shared 30x24 multiplier serves both axes in four passes per valid pixel.
// Reset restores the default camera registers and clears all accumulators.
module depth_roi_centroid
   import drc_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 640,
   parameter int IMAGE_HEIGHT = 480
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [9:0]            req_pixel_col,
   input  logic [8:0]            req_pixel_row,
   input  logic [DEPTH_W-1:0]    req_depth_mm,
   input  logic                  req_last_in_box,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [OUT_W-1:0] rsp_center_x,
   output logic signed [OUT_W-1:0] rsp_center_y,
   output logic signed [OUT_W-1:0] rsp_center_z,
   output logic                  rsp_found,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [12:0] COL_LIM = 13'(IMAGE_WIDTH);
   localparam logic [12:0] ROW_LIM = 13'(IMAGE_HEIGHT);

   state_type state_ff, state_in;

   logic [COORD_W-1:0] principal_x_ff, principal_y_ff;
   logic [INV_W-1:0]   inv_x_ff, inv_y_ff;
   logic [DEPTH_W-1:0] limit_ff;

   logic [9:0]         col_ff;
   logic [8:0]         row_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic               last_ff;

   logic [SUM_XY_W-1:0] sum_x_ff, sum_y_ff;
   logic [SUM_Z_W-1:0]  sum_z_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [OUT_W-1:0]    qx_ff, qy_ff, qz_ff;

   logic               rsp_valid_ff;
   logic [OUT_W-1:0]   rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic               rsp_found_ff;

   logic               accept;
   logic               ok_now;
   logic [COORD_W-1:0] pos_x, pos_y, mag_x, mag_y;
   logic               neg_x, neg_y;
   logic [MUL_A_W-1:0] mul_a;
   logic [INV_W-1:0]   mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic [SUM_XY_W-1:0] term;
   logic [SUM_Z_W:0]   sum_z_wide;
   logic [SUM_XY_W-1:0] abs_x, abs_y;
   logic               sneg_x, sneg_y;
   logic               div_start, div_done;
   logic [DIV_W-1:0]   div_dividend, div_quo;
   logic               load_rsp;
   logic [OUT_W-1:0]   sat_neg, sat_pos;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign ok_now = (req_depth_mm != '0) && (req_depth_mm < limit_ff) &&
                   ({3'b0, req_pixel_col} < COL_LIM) && ({4'b0, req_pixel_row} < ROW_LIM) &&
                   (count_ff != COUNT_MAX);

   always_comb begin
      pos_x = {col_ff, 4'b0};
      pos_y = {row_ff[8:0], 5'b0} >> 1;
      neg_x = pos_x < principal_x_ff;
      neg_y = pos_y < principal_y_ff;
      mag_x = neg_x ? COORD_W'(principal_x_ff - pos_x) : COORD_W'(pos_x - principal_x_ff);
      mag_y = neg_y ? COORD_W'(principal_y_ff - pos_y) : COORD_W'(pos_y - principal_y_ff);
   end

   always_comb begin
      case (state_ff)
         S_XA: begin
            mul_a = MUL_A_W'(mag_x);
            mul_b = INV_W'(depth_ff);
         end
         S_XB: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = inv_x_ff;
         end
         S_YA: begin
            mul_a = MUL_A_W'(mag_y);
            mul_b = INV_W'(depth_ff);
         end
         default: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = inv_y_ff;
         end
      endcase
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
      term  = SUM_XY_W'(prod_ff[PROD_W-1:FRAC_SHIFT]);
      sum_z_wide = {1'b0, sum_z_ff} + (SUM_Z_W + 1)'(depth_ff);
   end

   always_comb begin
      sneg_x = sum_x_ff[SUM_XY_W-1];
      sneg_y = sum_y_ff[SUM_XY_W-1];
      abs_x  = sneg_x ? SUM_XY_W'(-sum_x_ff) : sum_x_ff;
      abs_y  = sneg_y ? SUM_XY_W'(-sum_y_ff) : sum_y_ff;
      case (state_ff)
         S_FIN:   div_dividend = abs_x[DIV_W+7:8];
         S_DIV_X: div_dividend = abs_y[DIV_W+7:8];
         default: div_dividend = DIV_W'(sum_z_ff);
      endcase
      sat_neg = (div_quo > DIV_W'(32768)) ? OUT_NEG_MIN : OUT_W'(~div_quo[OUT_W-1:0] + 1'b1);
      sat_pos = (div_quo > DIV_W'(32767)) ? OUT_POS_MAX : div_quo[OUT_W-1:0];
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (ok_now) begin
                  state_in = S_XA;
               end else if (req_last_in_box) begin
                  state_in = S_FIN;
               end
            end
         end
         S_XA: state_in = S_XB;
         S_XB: state_in = S_YA;
         S_YA: state_in = S_YB;
         S_YB: state_in = S_ACC;
         S_ACC: state_in = last_ff ? S_FIN : S_IDLE;
         S_FIN: begin
            if (count_ff == '0) begin
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV_X;
            end
         end
         S_DIV_X: begin
            if (div_done) begin
               div_start = 1'b1;
               state_in  = S_DIV_Y;
            end
         end
         S_DIV_Y: begin
            if (div_done) begin
               div_start = 1'b1;
               state_in  = S_DIV_Z;
            end
         end
         S_DIV_Z: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         principal_x_ff <= PRINCIPAL_X_RESET;
         principal_y_ff <= PRINCIPAL_Y_RESET;
         inv_x_ff       <= INV_FOCAL_RESET;
         inv_y_ff       <= INV_FOCAL_RESET;
         limit_ff       <= DEPTH_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PRINCIPAL_X: principal_x_ff <= csr_wdata[COORD_W-1:0];
            CSR_PRINCIPAL_Y: principal_y_ff <= csr_wdata[COORD_W-1:0];
            CSR_INV_FOCAL_X: inv_x_ff       <= csr_wdata[INV_W-1:0];
            CSR_INV_FOCAL_Y: inv_y_ff       <= csr_wdata[INV_W-1:0];
            CSR_DEPTH_LIMIT: limit_ff       <= csr_wdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff   <= req_pixel_col;
         row_ff   <= req_pixel_row;
         depth_ff <= req_depth_mm;
         last_ff  <= req_last_in_box;
      end
      if (state_ff == S_XA || state_ff == S_XB || state_ff == S_YA || state_ff == S_YB) begin
         prod_ff <= mul_p;
      end
      if (state_ff == S_FIN) begin
         qx_ff <= '0;
         qy_ff <= '0;
         qz_ff <= '0;
      end
      if (div_done) begin
         case (state_ff)
            S_DIV_X: qx_ff <= sneg_x ? sat_neg : sat_pos;
            S_DIV_Y: qy_ff <= sneg_y ? sat_neg : sat_pos;
            default: qz_ff <= sat_pos;
         endcase
      end
      if (load_rsp) begin
         rsp_x_ff     <= qx_ff;
         rsp_y_ff     <= qy_ff;
         rsp_z_ff     <= qz_ff;
         rsp_found_ff <= (count_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
         count_ff <= '0;
      end else if (load_rsp) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
         count_ff <= '0;
      end else if (state_ff == S_YA) begin
         sum_x_ff <= neg_x ? SUM_XY_W'(sum_x_ff - term) : SUM_XY_W'(sum_x_ff + term);
      end else if (state_ff == S_ACC) begin
         sum_y_ff <= neg_y ? SUM_XY_W'(sum_y_ff - term) : SUM_XY_W'(sum_y_ff + term);
         sum_z_ff <= sum_z_wide[SUM_Z_W] ? '1 : sum_z_wide[SUM_Z_W-1:0];
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   drc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_center_x = rsp_x_ff;
   assign rsp_center_y = rsp_y_ff;
   assign rsp_center_z = rsp_z_ff;
   assign rsp_found    = rsp_found_ff;

endmodule

// File: tb/tb.sv
// Self-checking testbench for depth_roi_centroid: pixel boxes checked against a centroid predictor.
module tb;
   import drc_pkg::*;

   localparam int IMG_W = 640;
   localparam int IMG_H = 480;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES = 160;
   localparam int RANDOM_PIXELS = 1550;
   localparam int STEADY_PIXELS = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [9:0]         col;
      logic [8:0]         row;
      logic [DEPTH_W-1:0] depth;
      logic               last;
   } pixel_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
      logic                    found;
   } centroid_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [9:0] req_pixel_col = '0;
   logic [8:0] req_pixel_row = '0;
   logic [DEPTH_W-1:0] req_depth_mm = '0;
   logic req_last_in_box = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_center_x;
   logic signed [OUT_W-1:0] rsp_center_y;
   logic signed [OUT_W-1:0] rsp_center_z;
   logic rsp_found;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [COORD_W-1:0] cam_cx;
   logic [COORD_W-1:0] cam_cy;
   logic [INV_W-1:0] cam_inv_fx;
   logic [INV_W-1:0] cam_inv_fy;
   logic [DEPTH_W-1:0] cam_limit;

   logic signed [SUM_XY_W-1:0] sum_x;
   logic signed [SUM_XY_W-1:0] sum_y;
   logic [SUM_Z_W-1:0] sum_z;
   logic [COUNT_W-1:0] pixels_in_box;

   pixel_type pending_pixels[$];
   centroid_type expected_centroids[$];
   pixel_type next_pixel;
   pixel_type taken_pixel;
   centroid_type wanted;

   int unsigned pixels_queued = 0;
   int unsigned pixels_accepted = 0;
   int unsigned boxes_queued = 0;
   int unsigned centroids_seen = 0;
   int unsigned reg_writes = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned send_wait = 0;
   int unsigned send_calm = 0;
   int unsigned recv_wait = 0;
   int unsigned recv_calm = 0;
   logic steady_send = 1'b0;

   depth_roi_centroid #(
      .IMAGE_WIDTH(IMG_W),
      .IMAGE_HEIGHT(IMG_H)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel_col(req_pixel_col),
      .req_pixel_row(req_pixel_row),
      .req_depth_mm(req_depth_mm),
      .req_last_in_box(req_last_in_box),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_center_x(rsp_center_x),
      .rsp_center_y(rsp_center_y),
      .rsp_center_z(rsp_center_z),
      .rsp_found(rsp_found),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint world_offset(input int unsigned coord, input int unsigned center16,
                                           input int unsigned recip, input int unsigned depth);
      int unsigned pos16;
      longint unsigned mag;
      pos16 = coord * 16;
      if (pos16 < center16) mag = center16 - pos16;
      else mag = pos16 - center16;
      mag = (mag * recip * depth) >> FRAC_SHIFT;
      if (pos16 < center16) return -longint'(mag);
      return longint'(mag);
   endfunction

   function automatic logic signed [OUT_W-1:0] saturated_mean(input longint total,
                                                              input longint unsigned divisor);
      longint unsigned mag;
      longint unsigned q;
      mag = (total < 0) ? -total : total;
      q = mag / divisor;
      if (total < 0) begin
         if (q > 32768) q = 32768;
         return -q[OUT_W-1:0];
      end
      if (q > 32767) q = 32767;
      return q[OUT_W-1:0];
   endfunction

   function automatic void accum_pixel(input pixel_type p);
      logic usable;
      centroid_type c;
      longint unsigned divisor;
      longint unsigned mean_z;
      usable = p.depth != 0 && p.depth < cam_limit && p.col < IMG_W && p.row < IMG_H;
      if (usable && pixels_in_box < COUNT_MAX) begin
         sum_x = SUM_XY_W'(sum_x + world_offset(p.col, cam_cx, cam_inv_fx, p.depth));
         sum_y = SUM_XY_W'(sum_y + world_offset(p.row, cam_cy, cam_inv_fy, p.depth));
         if (sum_z > 32'hFFFF_FFFF - p.depth) sum_z = 32'hFFFF_FFFF;
         else sum_z = sum_z + p.depth;
         pixels_in_box = pixels_in_box + 1'b1;
      end
      if (p.last) begin
         c = '0;
         if (pixels_in_box != 0) begin
            divisor = pixels_in_box;
            c.x = saturated_mean(sum_x, divisor << 8);
            c.y = saturated_mean(sum_y, divisor << 8);
            mean_z = sum_z / divisor;
            if (mean_z > 32767) mean_z = 32767;
            c.z = mean_z[OUT_W-1:0];
            c.found = 1'b1;
         end
         expected_centroids.push_back(c);
         sum_x = '0;
         sum_y = '0;
         sum_z = '0;
         pixels_in_box = '0;
      end
   endfunction

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cam_cx <= PRINCIPAL_X_RESET;
         cam_cy <= PRINCIPAL_Y_RESET;
         cam_inv_fx <= INV_FOCAL_RESET;
         cam_inv_fy <= INV_FOCAL_RESET;
         cam_limit <= DEPTH_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PRINCIPAL_X: cam_cx <= csr_wdata[COORD_W-1:0];
            CSR_PRINCIPAL_Y: cam_cy <= csr_wdata[COORD_W-1:0];
            CSR_INV_FOCAL_X: cam_inv_fx <= csr_wdata[INV_W-1:0];
            CSR_INV_FOCAL_Y: cam_inv_fy <= csr_wdata[INV_W-1:0];
            CSR_DEPTH_LIMIT: cam_limit <= csr_wdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
         send_calm = 0;
         sum_x = '0;
         sum_y = '0;
         sum_z = '0;
         pixels_in_box = '0;
      end else begin
         if (req_valid && req_ready) begin
            taken_pixel = {req_pixel_col, req_pixel_row, req_depth_mm, req_last_in_box};
            accum_pixel(taken_pixel);
            pixels_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (send_wait > 0 || pending_pixels.size() == 0) begin
               req_valid <= 1'b0;
               if (send_wait > 0) send_wait--;
            end else begin
               next_pixel = pending_pixels.pop_front();
               req_pixel_col <= next_pixel.col;
               req_pixel_row <= next_pixel.row;
               req_depth_mm <= next_pixel.depth;
               req_last_in_box <= next_pixel.last;
               req_valid <= 1'b1;
               if (steady_send) begin
                  send_wait = 0;
               end else if (send_calm > 0) begin
                  send_wait = 0;
                  send_calm--;
               end else begin
                  send_wait = idle_length();
                  if ($urandom_range(39) == 0) send_calm = $urandom_range(20, 100);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
         recv_calm = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            centroids_seen++;
            if (expected_centroids.size() == 0) begin
               report($sformatf("unexpected centroid x=%0d y=%0d z=%0d found=%0b",
                                rsp_center_x, rsp_center_y, rsp_center_z, rsp_found));
            end else begin
               wanted = expected_centroids.pop_front();
               if (rsp_center_x !== wanted.x || rsp_center_y !== wanted.y ||
                   rsp_center_z !== wanted.z || rsp_found !== wanted.found) begin
                  report($sformatf({"centroid %0d: expected x=%0d y=%0d z=%0d found=%0b,",
                                    " got x=%0d y=%0d z=%0d found=%0b"}, centroids_seen,
                                   wanted.x, wanted.y, wanted.z, wanted.found,
                                   rsp_center_x, rsp_center_y, rsp_center_z, rsp_found));
               end
            end
         end
         if (recv_wait > 0) begin
            rsp_ready <= 1'b0;
            recv_wait--;
         end else begin
            rsp_ready <= 1'b1;
            if (recv_calm > 0) recv_calm--;
            else if ($urandom_range(3) == 0) recv_wait = idle_length();
            else if ($urandom_range(39) == 0) recv_calm = $urandom_range(20, 100);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles.", quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void add_pixel(input int unsigned col, input int unsigned row,
                                     input int unsigned depth, input logic last);
      pixel_type p;
      p.col = 10'(col);
      p.row = 9'(row);
      p.depth = DEPTH_W'(depth);
      p.last = last;
      pending_pixels.push_back(p);
      pixels_queued++;
      if (last) boxes_queued++;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reg_writes++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pixels_accepted != pixels_queued || expected_centroids.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_setup(output int unsigned limit);
      logic [CSR_DATA_W-1:0] data;
      int unsigned r;
      data = CSR_DATA_W'($urandom);
      data[COORD_W-1:0] = COORD_W'(($urandom_range(3) == 0) ? $urandom_range(16383) :
                                                              $urandom_range(4000, 6400));
      write_reg(CSR_PRINCIPAL_X, data);
      data = CSR_DATA_W'($urandom);
      data[COORD_W-1:0] = COORD_W'(($urandom_range(3) == 0) ? $urandom_range(16383) :
                                                              $urandom_range(3000, 4800));
      write_reg(CSR_PRINCIPAL_Y, data);
      data = CSR_DATA_W'(($urandom_range(2) == 0) ? $urandom : $urandom_range(16000, 70000));
      write_reg(CSR_INV_FOCAL_X, data);
      data = CSR_DATA_W'(($urandom_range(2) == 0) ? $urandom : $urandom_range(16000, 70000));
      write_reg(CSR_INV_FOCAL_Y, data);
      r = $urandom_range(5);
      if (r == 0) limit = $urandom_range(1, 65535);
      else if (r == 1) limit = 65535;
      else limit = $urandom_range(1000, 8000);
      data = CSR_DATA_W'($urandom);
      data[DEPTH_W-1:0] = DEPTH_W'(limit);
      write_reg(CSR_DEPTH_LIMIT, data);
   endtask

   task automatic random_box(input int unsigned limit);
      int unsigned n;
      int unsigned k;
      int unsigned r;
      int unsigned c;
      int unsigned rw;
      int unsigned d;
      logic noisy;
      noisy = $urandom_range(11) == 0;
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
      for (k = 0; k < n; k++) begin
         r = noisy ? $urandom_range(23) : $urandom_range(99);
         c = $urandom_range(IMG_W - 1);
         rw = $urandom_range(IMG_H - 1);
         d = (limit > 1) ? $urandom_range(1, limit - 1) : $urandom_range(65535);
         if (r < 6) d = 0;
         else if (r < 12) d = $urandom_range(limit, 65535);
         else if (r < 17) c = $urandom_range(IMG_W, 1023);
         else if (r < 21) rw = $urandom_range(IMG_H, 511);
         else if (r < 24) d = $urandom_range(65535);
         add_pixel(c, rw, d, k == n - 1);
      end
   endtask

   initial begin
      int unsigned limit;
      int unsigned phase;
      int unsigned start;
      int unsigned k;
      int unsigned random_pixels;
      random_pixels = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      add_pixel(0, 0, 0, 1'b1);
      add_pixel(0, 0, 1, 1'b0);
      add_pixel(639, 479, 3599, 1'b0);
      add_pixel(320, 240, 3600, 1'b0);
      add_pixel(640, 100, 1000, 1'b0);
      add_pixel(100, 480, 1000, 1'b0);
      add_pixel(1023, 511, 65535, 1'b0);
      add_pixel(320, 240, 1500, 1'b1);
      add_pixel(200, 100, 2000, 1'b0);
      add_pixel(300, 300, 0, 1'b1);
      wait_drained();

      write_reg(CSR_PRINCIPAL_X, 24'hFFC000);
      write_reg(CSR_PRINCIPAL_Y, 24'h000000);
      write_reg(CSR_INV_FOCAL_X, 24'hFFFFFF);
      write_reg(CSR_INV_FOCAL_Y, 24'hFFFFFF);
      write_reg(CSR_DEPTH_LIMIT, 24'h00FFFF);
      add_pixel(639, 479, 65534, 1'b0);
      add_pixel(639, 479, 65534, 1'b1);
      wait_drained();

      write_reg(CSR_PRINCIPAL_X, 24'h003FFF);
      write_reg(CSR_PRINCIPAL_Y, 24'hFFFFFF);
      add_pixel(0, 0, 65534, 1'b1);
      wait_drained();

      write_reg(CSR_DEPTH_LIMIT, 24'hFF0000);
      write_reg(CSR_INV_FOCAL_X, 24'h000000);
      write_reg(CSR_INV_FOCAL_Y, 24'h000000);
      write_reg(CSR_UNUSED, 24'hA5A5A5);
      add_pixel(320, 240, 100, 1'b0);
      add_pixel(10, 10, 1, 1'b1);
      wait_drained();

      write_reg(CSR_DEPTH_LIMIT, 24'h000002);
      add_pixel(5, 5, 1, 1'b1);
      wait_drained();

      for (phase = 0; random_pixels < RANDOM_PIXELS; phase++) begin
         random_setup(limit);
         if (phase == 1) begin
            write_reg(CSR_DEPTH_LIMIT, 24'h00FFFF);
            steady_send = 1'b1;
            for (k = 0; k < STEADY_PIXELS; k++)
               add_pixel($urandom_range(IMG_W - 1), $urandom_range(IMG_H - 1),
                         $urandom_range(65000, 65534), k == STEADY_PIXELS - 1);
            wait_drained();
            steady_send = 1'b0;
         end else begin
            start = pixels_queued;
            while (pixels_queued - start < 220) random_box(limit);
            random_pixels += pixels_queued - start;
            wait_drained();
         end
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_centroids.size() != 0)
         report($sformatf("%0d centroids never arrived", expected_centroids.size()));
      $display("Sent %0d pixels in %0d boxes over %0d register writes; %0d centroids checked.",
               pixels_accepted, boxes_queued, reg_writes, centroids_seen);
      $display("Covered empty boxes, out-of-image pixels, depth-limit edges and saturation.");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: depth_roi_centroid.f
rtl/drc_pkg.sv
rtl/drc_divider.sv
rtl/depth_roi_centroid.sv
tb/tb.sv
